// File: hw/rtl/nvrs_pkg.sv
// Shared types, codes and constants for the nearest-value request scheduler.
// No dependencies; imported by every module of the block.
package nvrs_pkg;

  localparam int VALUE_BITS    = 10;
  localparam int ID_BITS       = 4;
  localparam int NUM_REQ       = 16;
  localparam int CFG_BITS      = 5;
  localparam int STATUS_BITS   = 2;
  localparam int LS_BITS       = VALUE_BITS + 1;
  localparam int DIST_BITS     = VALUE_BITS + 1;
  localparam int MAX_BOARD_DEF = 16;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_WAITING = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_REJECT  = 2'd3;

  // Requester states
  typedef logic [1:0] rq_state_t;
  localparam rq_state_t RQ_IDLE        = 2'd0;
  localparam rq_state_t RQ_POSTED      = 2'd1;
  localparam rq_state_t RQ_POSTED_LAST = 2'd2;
  localparam rq_state_t RQ_FINISHED    = 2'd3;

  // Register indexes (byte address bit 2)
  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_REQUESTERS = 1'b1;

  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd3;
  localparam logic [CFG_BITS-1:0] REQ_RESET = 5'd5;

  typedef struct packed {
    logic [DIST_BITS-1:0] span;
    logic                 closer;
  } seek_res_t;

endpackage

// File: hw/rtl/nvrs_seek_unit.sv
// Shared distance and compare unit used once per scan step.
// Depends on nvrs_pkg.
module nvrs_seek_unit import nvrs_pkg::*; (
  input  logic signed [LS_BITS-1:0]   last_served,
  input  logic        [VALUE_BITS-1:0] cand_value,
  input  logic        [DIST_BITS-1:0]  best_dist,
  input  logic                         first,
  output seek_res_t                    res
);

  logic signed [LS_BITS:0] ls_x;
  logic signed [LS_BITS:0] cand_x;
  logic signed [LS_BITS:0] diff;
  logic signed [LS_BITS:0] mag;

  always_comb begin
    ls_x   = {last_served[LS_BITS-1], last_served};
    cand_x = signed'({2'b00, cand_value});
    diff   = ls_x - cand_x;
    mag    = diff[LS_BITS] ? -diff : diff;
    res.span   = mag[DIST_BITS-1:0];
    // strict less-than keeps the oldest entry on a tie
    res.closer = first || (res.span < best_dist);
  end

endmodule

// File: hw/rtl/nearest_value_request_scheduler.sv
// Nearest-value request scheduler: request board, scan sequencer, config regs.
// Depends on nvrs_pkg and nvrs_seek_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per action: a post
//   (action 0) places request_value for requester_id on the board; a serve
//   (action 1) removes the entry nearest the last served value, oldest first
//   on a tie. Every input beat yields exactly one output beat with status,
//   the served entry (zero unless a serve succeeds), the board count and the
//   all-finished flag.
//   A post or a serve on an empty board goes from idle straight to the
//   finish step, which registers the result beat; a serve over a non-empty
//   board first scans every entry, since the single distance unit visits
//   one entry per cycle, and then finishes. The finish step waits while the
//   output register still holds an untaken result.
//   in_ready is high only while the sequencer is idle, one item at a time.
//   The output register holds a result until taken; the next item may be
//   accepted meanwhile and waits in its final step while out_ready is low.
//   Reset empties the board, sets all requesters idle, last served to -1,
//   capacity to 3 and requester count to 5. Write the APB registers only
//   while no item is in flight.
module nearest_value_request_scheduler import nvrs_pkg::*; #(
  parameter int MAX_BOARD = MAX_BOARD_DEF  // 1..16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [ID_BITS-1:0]     requester_id,
  input  logic [VALUE_BITS-1:0]  request_value,
  input  logic                   is_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_BITS-1:0] status,
  output logic [ID_BITS-1:0]     served_requester,
  output logic [VALUE_BITS-1:0]  served_value,
  output logic [CFG_BITS-1:0]    board_count,
  output logic                   all_finished,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IDX_W = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam int CNT_W = $clog2(MAX_BOARD + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;

  logic [CFG_BITS-1:0] cfg_cap;
  logic [CFG_BITS-1:0] cfg_req;

  logic [VALUE_BITS-1:0] entry_value [MAX_BOARD];
  logic [ID_BITS-1:0]    entry_owner [MAX_BOARD];
  logic [CNT_W-1:0]      board_cnt;
  rq_state_t             rq_state [NUM_REQ];
  logic signed [LS_BITS-1:0] last_served;

  logic                  op_serve;
  logic [ID_BITS-1:0]    op_id;
  logic [VALUE_BITS-1:0] op_value;
  logic                  op_last;

  logic [CNT_W-1:0]      scan_idx;
  logic [IDX_W-1:0]      best_idx;
  logic [DIST_BITS-1:0]  best_dist;
  logic [VALUE_BITS-1:0] best_value;
  logic [ID_BITS-1:0]    best_owner;

  seek_res_t seek_res;

  logic                   cfg_wr;
  logic                   out_free;
  logic [CFG_BITS-1:0]    cap_eff;
  logic [CFG_BITS-1:0]    req_eff;
  logic                   board_full;
  logic                   idle_any;
  logic                   all_fin_c;
  logic [STATUS_BITS-1:0] status_c;
  logic                   do_post;
  logic                   do_serve;
  logic [CNT_W-1:0]       cnt_next;
  rq_state_t              rq_next [NUM_REQ];

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY:   prdata = {{(32-CFG_BITS){1'b0}}, cfg_cap};
      REG_REQUESTERS: prdata = {{(32-CFG_BITS){1'b0}}, cfg_req};
      default:        prdata = '0;
    endcase
  end

  nvrs_seek_unit u_seek (
    .last_served (last_served),
    .cand_value  (entry_value[scan_idx[IDX_W-1:0]]),
    .best_dist   (best_dist),
    .first       (scan_idx == '0),
    .res         (seek_res)
  );

  // Decide the outcome of the held item against the current board.
  always_comb begin
    cap_eff    = (cfg_cap > CFG_BITS'(MAX_BOARD)) ? CFG_BITS'(MAX_BOARD) : cfg_cap;
    req_eff    = (cfg_req > CFG_BITS'(NUM_REQ)) ? CFG_BITS'(NUM_REQ) : cfg_req;
    board_full = CFG_BITS'(board_cnt) >= cap_eff;
    idle_any   = 1'b0;
    for (int i = 0; i < NUM_REQ; i++) begin
      if ((CFG_BITS'(i) < req_eff) && (rq_state[i] == RQ_IDLE)) begin
        idle_any = 1'b1;
      end
      rq_next[i] = rq_state[i];
    end
    status_c = STAT_DONE;
    do_post  = 1'b0;
    do_serve = 1'b0;
    cnt_next = board_cnt;
    if (!op_serve) begin
      if (CFG_BITS'(op_id) >= req_eff) begin
        status_c = STAT_REJECT;
      end else if (rq_state[op_id] != RQ_IDLE) begin
        status_c = STAT_WAITING;
      end else if (board_full) begin
        status_c = STAT_FULL;
      end else begin
        do_post        = 1'b1;
        cnt_next       = board_cnt + CNT_W'(1);
        rq_next[op_id] = op_last ? RQ_POSTED_LAST : RQ_POSTED;
      end
    end else begin
      if (!(board_full || !idle_any) || board_cnt == '0) begin
        status_c = STAT_REJECT;
      end else begin
        do_serve            = 1'b1;
        cnt_next            = board_cnt - CNT_W'(1);
        rq_next[best_owner] = (rq_state[best_owner] == RQ_POSTED) ? RQ_IDLE : RQ_FINISHED;
      end
    end
    all_fin_c = 1'b1;
    for (int i = 0; i < NUM_REQ; i++) begin
      if ((CFG_BITS'(i) < req_eff) && (rq_next[i] != RQ_FINISHED)) begin
        all_fin_c = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cfg_cap     <= CAP_RESET;
      cfg_req     <= REQ_RESET;
      board_cnt   <= '0;
      last_served <= '1;
      out_valid   <= 1'b0;
      for (int i = 0; i < NUM_REQ; i++) begin
        rq_state[i] <= RQ_IDLE;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_REQUESTERS) begin
          cfg_req <= pwdata[CFG_BITS-1:0];
        end else begin
          cfg_cap <= pwdata[CFG_BITS-1:0];
        end
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (action && board_cnt != '0) ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if ((scan_idx + CNT_W'(1)) == board_cnt) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold here until the output register frees up
          if (out_free) begin
            state     <= S_IDLE;
            board_cnt <= cnt_next;
            for (int i = 0; i < NUM_REQ; i++) begin
              rq_state[i] <= rq_next[i];
            end
            if (do_serve) begin
              last_served <= signed'({1'b0, best_value});
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: held item, scan registers, board entries, result beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_serve <= action;
      op_id    <= requester_id;
      op_value <= request_value;
      op_last  <= is_last;
      scan_idx <= '0;
    end
    if (state == S_SCAN) begin
      if (seek_res.closer) begin
        best_idx   <= scan_idx[IDX_W-1:0];
        best_dist  <= seek_res.span;
        best_value <= entry_value[scan_idx[IDX_W-1:0]];
        best_owner <= entry_owner[scan_idx[IDX_W-1:0]];
      end
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (state == S_FINISH && out_free) begin
      status           <= status_c;
      served_requester <= do_serve ? best_owner : '0;
      served_value     <= do_serve ? best_value : '0;
      board_count      <= CFG_BITS'(cnt_next);
      all_finished     <= (cnt_next == '0) && all_fin_c;
      if (do_post) begin
        entry_value[board_cnt[IDX_W-1:0]] <= op_value;
        entry_owner[board_cnt[IDX_W-1:0]] <= op_id;
      end
      // close the gap left by the served entry
      for (int i = 0; i < MAX_BOARD - 1; i++) begin
        if (do_serve && IDX_W'(i) >= best_idx && CNT_W'(i + 1) < board_cnt) begin
          entry_value[i] <= entry_value[i + 1];
          entry_owner[i] <= entry_owner[i + 1];
        end
      end
    end
  end

endmodule

// File: hw/rtl/nvrs_checker.sv
// Port-level checks for the nearest-value request scheduler, bound to the top.
// Depends on nvrs_pkg.
module nvrs_checker import nvrs_pkg::*; #(
  parameter int MAX_BOARD = MAX_BOARD_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic [STATUS_BITS-1:0] status,
  input logic [ID_BITS-1:0]     served_requester,
  input logic [VALUE_BITS-1:0]  served_value,
  input logic [CFG_BITS-1:0]    board_count,
  input logic                   all_finished
);

  a_reset_empties_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_failed_serves_nothing: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_DONE |-> served_requester == '0 && served_value == '0)
    else $error("served fields set on a rejected beat");

  a_finished_means_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_finished |-> board_count == '0)
    else $error("all_finished with entries still on the board");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> board_count <= CFG_BITS'(MAX_BOARD))
    else $error("board count exceeds board size");

endmodule

bind nearest_value_request_scheduler nvrs_checker #(.MAX_BOARD(MAX_BOARD)) u_nvrs_checker (.*);

// File: test/nearest_value_request_scheduler_tb.sv
// Testbench for the nearest-value request scheduler: directed and random post/serve
// beats checked against a cycle-free board predictor held in a scoreboard class.
// Depends on nvrs_pkg and the nearest_value_request_scheduler RTL.
`timescale 1ns / 1ps

module nearest_value_request_scheduler_tb;
  import nvrs_pkg::*;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     requester;
    logic [VALUE_BITS-1:0]  value;
    logic [CFG_BITS-1:0]    count;
    logic                   done;
  } sched_result_t;

  class sched_scoreboard;
    logic [CFG_BITS-1:0]   capacity_reg;
    logic [CFG_BITS-1:0]   requesters_reg;
    logic [VALUE_BITS-1:0] slot_value [MAX_BOARD_DEF];
    logic [ID_BITS-1:0]    slot_owner [MAX_BOARD_DEF];
    int unsigned           slot_count;
    rq_state_t             rq_state [NUM_REQ];
    int                    last_value;
    sched_result_t         pending_results [$];
    int unsigned           mismatches;
    int unsigned           results_seen;

    function new();
      capacity_reg   = CAP_RESET;
      requesters_reg = REQ_RESET;
      slot_count     = 0;
      last_value     = -1;
      mismatches     = 0;
      results_seen   = 0;
      foreach (rq_state[i]) rq_state[i] = RQ_IDLE;
    endfunction

    function void set_register(logic idx, logic [CFG_BITS-1:0] value);
      if (idx == REG_CAPACITY) capacity_reg = value;
      else requesters_reg = value;
    endfunction

    function int unsigned capacity();
      return (capacity_reg > MAX_BOARD_DEF) ? MAX_BOARD_DEF : capacity_reg;
    endfunction

    function int unsigned active_count();
      return (requesters_reg > NUM_REQ) ? NUM_REQ : requesters_reg;
    endfunction

    function bit serve_allowed();
      if (slot_count >= capacity()) return 1'b1;
      for (int i = 0; i < active_count(); i++)
        if (rq_state[i] == RQ_IDLE) return 1'b0;
      return 1'b1;
    endfunction

    function bit everyone_finished();
      for (int i = 0; i < active_count(); i++)
        if (rq_state[i] != RQ_FINISHED) return 1'b0;
      return 1'b1;
    endfunction

    function sched_result_t predict_step(bit act, logic [ID_BITS-1:0] id,
                                         logic [VALUE_BITS-1:0] val, bit last);
      sched_result_t r;
      int unsigned   best;
      int            best_d;
      int            d;
      logic [ID_BITS-1:0] owner;
      r = '0;
      r.status = STAT_DONE;
      if (!act) begin
        if (id >= active_count()) r.status = STAT_REJECT;
        else if (rq_state[id] != RQ_IDLE) r.status = STAT_WAITING;
        else if (slot_count >= capacity()) r.status = STAT_FULL;
        else begin
          slot_value[slot_count] = val;
          slot_owner[slot_count] = id;
          slot_count++;
          rq_state[id] = last ? RQ_POSTED_LAST : RQ_POSTED;
        end
      end else if (!serve_allowed() || slot_count == 0) begin
        r.status = STAT_REJECT;
      end else begin
        // nearest to the last served value; strict compare keeps the oldest on a tie
        best = 0;
        best_d = int'(slot_value[0]) - last_value;
        if (best_d < 0) best_d = -best_d;
        for (int i = 1; i < slot_count; i++) begin
          d = int'(slot_value[i]) - last_value;
          if (d < 0) d = -d;
          if (d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        owner = slot_owner[best];
        r.requester = owner;
        r.value = slot_value[best];
        last_value = int'(slot_value[best]);
        rq_state[owner] = (rq_state[owner] == RQ_POSTED) ? RQ_IDLE : RQ_FINISHED;
        for (int i = best; i + 1 < slot_count; i++) begin
          slot_value[i] = slot_value[i + 1];
          slot_owner[i] = slot_owner[i + 1];
        end
        slot_count--;
      end
      r.count = slot_count[CFG_BITS-1:0];
      r.done = (slot_count == 0) && everyone_finished();
      return r;
    endfunction

    function void note_item(bit act, logic [ID_BITS-1:0] id,
                            logic [VALUE_BITS-1:0] val, bit last);
      pending_results.insert(pending_results.size(), predict_step(act, id, val, last));
    endfunction

    task report(string msg);
      // keep the log short on a badly broken build
      if (mismatches < 100) $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [STATUS_BITS-1:0] st, logic [ID_BITS-1:0] rq,
                      logic [VALUE_BITS-1:0] val, logic [CFG_BITS-1:0] cnt, logic done);
      sched_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status)
        report($sformatf("result %0d status %0d, want %0d", results_seen, st, want.status));
      if (rq !== want.requester)
        report($sformatf("result %0d served_requester %0d, want %0d", results_seen, rq,
                         want.requester));
      if (val !== want.value)
        report($sformatf("result %0d served_value %0d, want %0d", results_seen, val,
                         want.value));
      if (cnt !== want.count)
        report($sformatf("result %0d board_count %0d, want %0d", results_seen, cnt,
                         want.count));
      if (done !== want.done)
        report($sformatf("result %0d all_finished %0b, want %0b", results_seen, done,
                         want.done));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   action = 1'b0;
  logic [ID_BITS-1:0]     requester_id = '0;
  logic [VALUE_BITS-1:0]  request_value = '0;
  logic                   is_last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]     served_requester;
  logic [VALUE_BITS-1:0]  served_value;
  logic [CFG_BITS-1:0]    board_count;
  logic                   all_finished;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  sched_scoreboard sb;
  int unsigned     send_burst = 0;

  nearest_value_request_scheduler u_top (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, served_requester, served_value, board_count, all_finished);
  end

  // mostly back-to-back or short gaps, now and then a long one or a gap-free stretch
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic offer(input bit act, input logic [ID_BITS-1:0] id,
                       input logic [VALUE_BITS-1:0] val, input bit last);
    int unsigned gap;
    in_valid <= 1'b1;
    action <= act;
    requester_id <= id;
    request_value <= val;
    is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(act, id, val, last);
    gap = pick_gap(send_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic serve_one();
    offer(1'b1, ID_BITS'($urandom_range(0, 15)), VALUE_BITS'($urandom_range(0, 1023)),
          1'($urandom_range(0, 1)));
  endtask

  // hold input until the board has reported every beat sent so far
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed traffic: serve when allowed, else post from an idle requester
  function automatic void pick_item(output bit act, output logic [ID_BITS-1:0] id,
                                    output logic [VALUE_BITS-1:0] val, output bit last);
    int unsigned idle_ids [$];
    int unsigned unfinished;
    int          near;
    unfinished = 0;
    for (int i = 0; i < sb.active_count(); i++) begin
      if (sb.rq_state[i] == RQ_IDLE) idle_ids.insert(idle_ids.size(), i);
      if (sb.rq_state[i] != RQ_FINISHED) unfinished++;
    end
    act = 1'($urandom_range(0, 1));
    id = ID_BITS'($urandom_range(0, 15));
    val = VALUE_BITS'($urandom_range(0, 1023));
    last = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 7) == 0) return;
    if (sb.slot_count != 0 && sb.serve_allowed() &&
        (idle_ids.size() == 0 || $urandom_range(0, 2) != 0)) begin
      act = 1'b1;
      return;
    end
    act = 1'b0;
    if (idle_ids.size() == 0) return;
    id = ID_BITS'(idle_ids[$urandom_range(0, idle_ids.size() - 1)]);
    // leave a couple of requesters unfinished so later phases still move
    last = (unfinished > 2) && ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 3))
      0: val = ($urandom_range(0, 1) != 0) ? '1 : '0;
      1: begin
        // land near the last served value to force distance ties
        near = sb.last_value + int'($urandom_range(0, 8)) - 4;
        if (near < 0) near = 0;
        if (near > 1023) near = 1023;
        val = near[VALUE_BITS-1:0];
      end
      default: ;
    endcase
  endfunction

  initial begin : receiver
    int unsigned hold;
    int unsigned burst;
    bit          held_long;
    hold = 0;
    burst = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_long && sb.results_seen >= 400) begin
        // long back-pressure: let the sender fill the block and stall
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap(burst);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_BITS-1:0]   phase_cap [6];
    logic [CFG_BITS-1:0]   phase_req [6];
    bit                    act;
    logic [ID_BITS-1:0]    id;
    logic [VALUE_BITS-1:0] val;
    bit                    last;
    int unsigned           waited;
    phase_cap = '{5'd4, 5'd8, 5'd1, 5'd31, 5'd16, 5'd16};
    phase_req = '{5'd3, 5'd8, 5'd16, 5'd31, 5'd12, 5'd16};
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, capacity 3 and five requesters
    serve_one();                   // empty board
    offer(1'b0, 4'd7, 10'd100, 1'b0);  // inactive poster
    offer(1'b0, 4'd0, 10'd0, 1'b0);
    offer(1'b0, 4'd0, 10'd5, 1'b0);    // already waiting
    offer(1'b0, 4'd1, 10'd1023, 1'b0);
    offer(1'b0, 4'd2, 10'd500, 1'b0);
    offer(1'b0, 4'd3, 10'd9, 1'b0);    // board full
    serve_one();                   // start value -1 picks 0
    offer(1'b0, 4'd4, 10'd1023, 1'b1);
    serve_one();
    serve_one();                   // not full and idle requesters remain
    offer(1'b0, 4'd3, 10'd1000, 1'b0);
    serve_one();
    offer(1'b0, 4'd0, 10'd977, 1'b0);
    serve_one();                   // three-way tie, oldest wins
    drain();
    write_reg(REG_CAPACITY, 5'd1);     // capacity now below the count
    offer(1'b0, 4'd2, 10'd77, 1'b0);
    serve_one();
    serve_one();
    serve_one();
    drain();
    write_reg(REG_REQUESTERS, 5'd1);
    write_reg(REG_CAPACITY, 5'd16);
    offer(1'b0, 4'd0, 10'd42, 1'b1);
    offer(1'b0, 4'd1, 10'd42, 1'b0);
    serve_one();                   // sole requester finishes
    drain();
    write_reg(REG_REQUESTERS, 5'd0);
    write_reg(REG_CAPACITY, 5'd0);
    offer(1'b0, 4'd0, 10'd3, 1'b0);
    serve_one();
    drain();
    write_reg(REG_REQUESTERS, 5'd16);
    offer(1'b0, 4'd5, 10'd300, 1'b0);  // capacity zero
    serve_one();

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(REG_CAPACITY, phase_cap[p]);
      write_reg(REG_REQUESTERS, phase_req[p]);
      for (int k = 0; k < 130; k++) begin
        if (p == 2 && k == 60) drain();
        pick_item(act, id, val, last);
        offer(act, id, val, last);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // wait past a full-board serve so that stray beats can show up
    repeat (40) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
